/* design/lsbd_pkg.sv */
// Shared types and constants for the line-scan binarize/despeckle block.
// No dependencies; compiled first.
`default_nettype none

package lsbd_pkg;

    localparam int LINE_LEN_DEF   = 128;
    localparam int TAIL_START_DEF = 120;
    localparam int MAX_GROUPS     = 16;
    localparam int PIX_W          = 8;
    localparam int GRP_W          = 4;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [GRP_W-1:0] t_group;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BIN,
        ST_PASS1,
        ST_PASS2,
        ST_TAIL,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // pixel beat accepted
        logic rd_en;      // read line store for thresholding
        logic p1_en;      // lone-pixel pass step
        logic p1_ok;      // position is a lone-pixel candidate
        logic p2_en;      // pair pass step
        logic p2_ok;      // position is a pair candidate
        logic tail_en;    // force tail bright
        logic out_shift;  // output beat taken, move to next group
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_last;  // next pixel completes the line
    } t_stat;

endpackage

`default_nettype wire

/* design/lsbd_pix_if.sv */
// Pixel input channel: valid/ready handshake with one 8-bit sample per beat.
// Depends on lsbd_pkg.
`default_nettype none

interface lsbd_pix_if;
    logic            valid;
    logic            ready;
    lsbd_pkg::t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

/* design/lsbd_grp_if.sv */
// Result channel: one packed group of eight binary pixels per beat.
// Depends on lsbd_pkg.
`default_nettype none

interface lsbd_grp_if;
    logic             valid;
    logic             ready;
    lsbd_pkg::t_pixel bits;
    lsbd_pkg::t_group group;
    lsbd_pkg::t_pixel threshold;
    logic             last;

    modport source (output valid, output bits, output group, output threshold, output last,
                    input ready);
    modport sink   (input valid, input bits, input group, input threshold, input last,
                    output ready);
endinterface

`default_nettype wire

/* design/line_scan_binarize_despeckle_core.sv */
// Line-scan binarizer with despeckle: top level joining controller and datapath.
// Depends on lsbd_pkg, lsbd_pix_if, lsbd_grp_if, lsbd_ctrl, lsbd_dpath.
//
// Pixels of a line are accepted one per cycle. The beat that completes the line
// starts processing: the threshold scan (line store read port), the lone-pixel
// pass and the pair pass, each stepping once through every pixel position (one
// shift-register rotation per position), then one tail step. Then
// min(ceil(LINE_LEN/8),16) group beats are offered, each carrying the line's
// threshold. While groups drain, pixels of the next line are accepted, up to
// but not including the one that completes it; input stalls during processing.
`default_nettype none

module line_scan_binarize_despeckle_core #(
    parameter int LINE_LEN   = lsbd_pkg::LINE_LEN_DEF,
    parameter int TAIL_START = lsbd_pkg::TAIL_START_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lsbd_pix_if.sink     i_pix,
    lsbd_grp_if.source   o_grp
);
    import lsbd_pkg::*;

    localparam int AW = $clog2(LINE_LEN);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [AW-1:0] w_rd_addr;
    logic          w_in_ready;
    logic          w_out_valid;
    t_group        w_group;
    logic          w_last;
    t_pixel        w_bits;
    t_pixel        w_thr;

    lsbd_ctrl #(
        .LINE_LEN (LINE_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_grp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_group     (w_group),
        .o_last      (w_last)
    );

    lsbd_dpath #(
        .LINE_LEN   (LINE_LEN),
        .TAIL_START (TAIL_START)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_pixel   (i_pix.pixel),
        .i_rd_addr (w_rd_addr),
        .o_stat    (w_stat),
        .o_bits    (w_bits),
        .o_thr     (w_thr)
    );

    assign i_pix.ready     = w_in_ready;
    assign o_grp.valid     = w_out_valid;
    assign o_grp.bits      = w_bits;
    assign o_grp.group     = w_group;
    assign o_grp.threshold = w_thr;
    assign o_grp.last      = w_last;

    // a completing pixel must never land while the previous line is still draining
    a_no_complete_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_stat.load_last) |-> !w_in_ready)
        else $error("line completed while groups pending");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && o_grp.ready && w_last) |=> !w_out_valid)
        else $error("output valid right after last group");

    a_group_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && o_grp.ready && !w_last) |=>
            (w_out_valid && (w_group == GRP_W'($past(w_group) + 1'b1))))
        else $error("group index did not advance");

    a_thr_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && $past(w_out_valid)) |-> $stable(w_thr))
        else $error("threshold changed during emission");

endmodule

`default_nettype wire

/* design/lsbd_ctrl.sv */
// Controller state machine: load, threshold scan, two filter passes, tail, emit.
// Depends on lsbd_pkg.
`default_nettype none

module lsbd_ctrl #(
    parameter int LINE_LEN = lsbd_pkg::LINE_LEN_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    input  lsbd_pkg::t_stat             i_stat,
    output lsbd_pkg::t_cmd              o_cmd,
    output logic [$clog2(LINE_LEN)-1:0] o_rd_addr,
    output lsbd_pkg::t_group            o_group,
    output logic                        o_last
);
    import lsbd_pkg::*;

    localparam int AW     = $clog2(LINE_LEN);
    localparam int CW     = $clog2(LINE_LEN + 1);
    localparam int GROUPS = ((LINE_LEN + 7) / 8 > MAX_GROUPS) ? MAX_GROUPS
                                                               : (LINE_LEN + 7) / 8;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_group        r_grp, n_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_grp   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_grp   <= n_grp;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_grp       = r_grp;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_stat.load_last) begin
                    n_state = ST_BIN;
                    n_cnt   = '0;
                end
            end
            ST_BIN: begin
                // read data and its valid flag are registered, so run one extra step
                o_cmd.rd_en = (r_cnt != CW'(LINE_LEN));
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CW'(LINE_LEN)) begin
                    n_state = ST_PASS1;
                    n_cnt   = '0;
                end
            end
            ST_PASS1: begin
                o_cmd.p1_en = 1'b1;
                o_cmd.p1_ok = (r_cnt != '0) && (r_cnt != CW'(LINE_LEN - 1));
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CW'(LINE_LEN - 1)) begin
                    n_state = ST_PASS2;
                    n_cnt   = '0;
                end
            end
            ST_PASS2: begin
                o_cmd.p2_en = 1'b1;
                o_cmd.p2_ok = (r_cnt != '0) && (r_cnt <= CW'(LINE_LEN - 3));
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CW'(LINE_LEN - 1)) begin
                    n_state = ST_TAIL;
                    n_cnt   = '0;
                end
            end
            ST_TAIL: begin
                o_cmd.tail_en = 1'b1;
                n_state       = ST_EMIT;
                n_grp         = '0;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                // the next line may load, but not complete, while groups drain
                o_in_ready  = !i_stat.load_last;
                o_cmd.load  = i_in_valid && !i_stat.load_last;
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    if (r_grp == GRP_W'(GROUPS - 1)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_grp = r_grp + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_rd_addr = r_cnt[AW-1:0];
    assign o_group   = r_grp;
    assign o_last    = (r_grp == GRP_W'(GROUPS - 1));

endmodule

`default_nettype wire

/* design/lsbd_dpath.sv */
// Datapath: line store memory, min/max tracking, threshold, binary line
// shift register with filter taps, output packing. Depends on lsbd_pkg.
`default_nettype none

module lsbd_dpath #(
    parameter int LINE_LEN   = lsbd_pkg::LINE_LEN_DEF,
    parameter int TAIL_START = lsbd_pkg::TAIL_START_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  lsbd_pkg::t_cmd              i_cmd,
    input  lsbd_pkg::t_pixel            i_pixel,
    input  wire [$clog2(LINE_LEN)-1:0]  i_rd_addr,
    output lsbd_pkg::t_stat             o_stat,
    output lsbd_pkg::t_pixel            o_bits,
    output lsbd_pkg::t_pixel            o_thr
);
    import lsbd_pkg::*;

    localparam int AW = $clog2(LINE_LEN);

    t_pixel              r_mem [LINE_LEN];
    t_pixel              r_rd_data;
    logic                r_rd_v;
    logic [AW-1:0]       r_load_cnt, n_load_cnt;
    t_pixel              r_max, n_max;
    t_pixel              r_min, n_min;
    t_pixel              r_thr, n_thr;
    logic [LINE_LEN-1:0] r_line, n_line;
    logic [LINE_LEN-1:0] w_tail;
    t_pixel              w_max, w_min;
    logic                w_flip1, w_flip2;
    logic                w_last;

    assign w_last = (r_load_cnt == AW'(LINE_LEN - 1));
    assign w_max  = (i_pixel > r_max) ? i_pixel : r_max;
    assign w_min  = (i_pixel < r_min) ? i_pixel : r_min;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_load_cnt] <= i_pixel;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_comb begin
        n_load_cnt = r_load_cnt;
        n_max      = r_max;
        n_min      = r_min;
        n_thr      = r_thr;
        if (i_cmd.load) begin
            if (w_last) begin
                n_load_cnt = '0;
                n_max      = PIX_MIN;
                n_min      = PIX_MAX;
                n_thr      = PIX_W'(({1'b0, w_max} + {1'b0, w_min}) >> 1);
            end else begin
                n_load_cnt = r_load_cnt + 1'b1;
                n_max      = w_max;
                n_min      = w_min;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LINE_LEN; k++) begin
            w_tail[k] = (k >= TAIL_START);
        end
    end

    // bit 0 is the current position, bit LINE_LEN-1 the already-filtered left
    // neighbor; each step rotates right so the line realigns after a pass
    assign w_flip1 = i_cmd.p1_ok && (r_line[0] != r_line[LINE_LEN-1])
                                 && (r_line[0] != r_line[1]);
    assign w_flip2 = i_cmd.p2_ok && (r_line[0] == r_line[1])
                                 && (r_line[0] != r_line[LINE_LEN-1])
                                 && (r_line[0] != r_line[2]);

    always_comb begin
        priority if (i_cmd.out_shift) begin
            n_line = r_line >> 8;
        end else if (r_rd_v) begin
            n_line = {(r_rd_data >= r_thr), r_line[LINE_LEN-1:1]};
        end else if (i_cmd.p1_en) begin
            n_line = {r_line[0] ^ w_flip1, r_line[LINE_LEN-1:1]};
        end else if (i_cmd.p2_en) begin
            n_line = {r_line[0] ^ w_flip2, r_line[LINE_LEN-1:2], r_line[1] ^ w_flip2};
        end else if (i_cmd.tail_en) begin
            n_line = r_line | w_tail;
        end else begin
            n_line = r_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_max      <= PIX_MIN;
            r_min      <= PIX_MAX;
            r_rd_v     <= 1'b0;
        end else begin
            r_load_cnt <= n_load_cnt;
            r_max      <= n_max;
            r_min      <= n_min;
            r_rd_v     <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr  <= n_thr;
        r_line <= n_line;
    end

    assign o_stat.load_last = w_last;
    assign o_bits           = r_line[7:0];
    assign o_thr            = r_thr;

endmodule

`default_nettype wire
